>>> src/fmmx_pkg.sv
`timescale 1ns / 1ps
// Shared package for the min/max extract queue: command and status codes,
// value limits and the controller/datapath interface structs. No dependencies.
package fmmx_pkg;

  localparam int unsigned DEPTH_DEF = 16;

  localparam int unsigned CMD_W    = 3;
  localparam int unsigned VAL_W    = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W  = 5;

  localparam logic [CMD_W-1:0] CMD_APPEND     = 3'd0;
  localparam logic [CMD_W-1:0] CMD_POP_OLDEST = 3'd1;
  localparam logic [CMD_W-1:0] CMD_POP_MIN    = 3'd2;
  localparam logic [CMD_W-1:0] CMD_POP_MAX    = 3'd3;
  localparam logic [CMD_W-1:0] CMD_QUERY      = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  localparam logic [VAL_W-1:0] INT_MIN = 32'h8000_0000;
  localparam logic [VAL_W-1:0] INT_MAX = 32'h7FFF_FFFF;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;        // latch a new command
    logic scan;        // step the search over stored entries
    logic shift_init;  // point the compaction past the chosen entry
    logic shift;       // step the compaction
    logic fin;         // commit count and load the result register
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic start_scan;  // incoming command removes from a non-empty queue
    logic scan_done;
    logic shift_done;
  } dp_sts_t;

endpackage

>>> src/fmmx_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module fmmx_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/fmmx_ctrl.sv
`timescale 1ns / 1ps
// Controller for the min/max extract queue: sequences scan, compaction and
// result hand-off. Depends on fmmx_pkg.
module fmmx_ctrl import fmmx_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  input  dp_sts_t sts_i,
  output dp_cmd_t ctl_o
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_SHIFT = 2'd2;
  localparam logic [1:0] S_FIN   = 2'd3;

  logic [1:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       fin_ok;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  // The result register is free once its transfer completes.
  assign fin_ok      = !out_valid_q || out_ready_i;

  always_comb begin
    state_d          = state_q;
    out_valid_d      = out_valid_q && !out_ready_i;
    ctl_o            = '0;
    ctl_o.load       = in_valid_i && in_ready_o;
    ctl_o.scan       = (state_q == S_SCAN);
    ctl_o.shift      = (state_q == S_SHIFT);
    ctl_o.shift_init = (state_q == S_SCAN) && sts_i.scan_done;
    ctl_o.fin        = (state_q == S_FIN) && fin_ok;
    case (state_q)
      S_IDLE: begin
        if (ctl_o.load) begin
          state_d = sts_i.start_scan ? S_SCAN : S_FIN;
        end
      end
      S_SCAN: begin
        if (sts_i.scan_done) begin
          state_d = S_SHIFT;
        end
      end
      S_SHIFT: begin
        if (sts_i.shift_done) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (fin_ok) begin
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

>>> src/fmmx_dp.sv
`timescale 1ns / 1ps
// Datapath for the min/max extract queue: entry RAM, count, search and
// compaction pointers, result register. Depends on fmmx_pkg and fmmx_ram.
module fmmx_dp import fmmx_pkg::*; #(
  parameter int unsigned DEPTH = DEPTH_DEF,
  localparam int unsigned AW = $clog2(DEPTH),
  localparam int unsigned CW = $clog2(DEPTH + 1)
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic        [CMD_W-1:0]    cmd_i,
  input  logic signed [VAL_W-1:0]    value_i,
  input  dp_cmd_t                    ctl_i,
  output dp_sts_t                    sts_o,
  output logic signed [VAL_W-1:0]    value_res_o,
  output logic        [STATUS_W-1:0] status_o,
  output logic        [COUNT_W-1:0]  count_o
);

  logic [CMD_W-1:0]    cmd_q;
  logic [VAL_W-1:0]    val_q;
  logic [CW-1:0]       cnt_q, cnt_d;
  logic [CW-1:0]       rd_idx_q, rd_idx_d;
  logic [CW-1:0]       lim_q;
  logic [VAL_W-1:0]    best_val_q, best_val_d;
  logic [AW-1:0]       best_idx_q, best_idx_d;
  logic                rdat_vld_q, rdat_vld_d;
  logic [AW-1:0]       rdat_idx_q, rdat_idx_d;
  logic [VAL_W-1:0]    res_q, res_n;
  logic [STATUS_W-1:0] st_q, st_n;
  logic [COUNT_W-1:0]  cnt_out_q;
  logic [31:0]         cnt_wide;

  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  logic [VAL_W-1:0]    ram_wdata;
  logic [VAL_W-1:0]    ram_rdata;
  logic                app_we;
  logic                in_pop;
  logic                better;
  logic [CW-1:0]       fin_cnt;

  fmmx_ram #(
    .WIDTH (VAL_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (rd_idx_q[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  assign in_pop = (cmd_i inside {CMD_POP_OLDEST, CMD_POP_MIN, CMD_POP_MAX});

  assign sts_o.start_scan = in_pop && (cnt_q != '0);
  assign sts_o.scan_done  = (rd_idx_q >= lim_q) && !rdat_vld_q;
  assign sts_o.shift_done = (rd_idx_q >= cnt_q) && !rdat_vld_q;

  // Strict compare keeps the earliest of tied entries.
  assign better = (cmd_q == CMD_POP_MAX) ? ($signed(ram_rdata) > $signed(best_val_q))
                                         : ($signed(ram_rdata) < $signed(best_val_q));

  // Search and compaction pointers.
  always_comb begin
    rd_idx_d   = rd_idx_q;
    rdat_vld_d = 1'b0;
    rdat_idx_d = rdat_idx_q;
    best_val_d = best_val_q;
    best_idx_d = best_idx_q;
    if (ctl_i.load) begin
      rd_idx_d = '0;
    end
    if (ctl_i.scan) begin
      if (rd_idx_q < lim_q) begin
        rd_idx_d   = rd_idx_q + CW'(1);
        rdat_vld_d = 1'b1;
        rdat_idx_d = rd_idx_q[AW-1:0];
      end
      if (rdat_vld_q && ((rdat_idx_q == '0) || better)) begin
        best_val_d = ram_rdata;
        best_idx_d = rdat_idx_q;
      end
    end
    if (ctl_i.shift_init) begin
      rd_idx_d   = CW'(best_idx_q) + CW'(1);
      rdat_vld_d = 1'b0;
    end
    if (ctl_i.shift) begin
      if (rd_idx_q < cnt_q) begin
        rd_idx_d   = rd_idx_q + CW'(1);
        rdat_vld_d = 1'b1;
        rdat_idx_d = rd_idx_q[AW-1:0];
      end
    end
  end

  // Result and new count for the command in flight.
  always_comb begin
    res_n   = '0;
    st_n    = ST_OK;
    fin_cnt = cnt_q;
    app_we  = 1'b0;
    case (cmd_q)
      CMD_APPEND: begin
        if (cnt_q == CW'(DEPTH)) begin
          st_n = ST_FULL;
        end else begin
          app_we  = 1'b1;
          fin_cnt = cnt_q + CW'(1);
        end
      end
      CMD_POP_OLDEST, CMD_POP_MIN, CMD_POP_MAX: begin
        if (cnt_q == '0) begin
          st_n = ST_EMPTY;
          if (cmd_q == CMD_POP_MIN) begin
            res_n = INT_MIN;
          end else if (cmd_q == CMD_POP_MAX) begin
            res_n = INT_MAX;
          end
        end else begin
          res_n   = best_val_q;
          fin_cnt = cnt_q - CW'(1);
        end
      end
      default: begin
        res_n = '0;
      end
    endcase
  end

  assign cnt_d    = ctl_i.fin ? fin_cnt : cnt_q;
  assign cnt_wide = 32'(fin_cnt);

  // Compaction moves each later entry down by one; append writes at the tail.
  always_comb begin
    if (ctl_i.shift) begin
      ram_we    = rdat_vld_q;
      ram_waddr = rdat_idx_q - AW'(1);
      ram_wdata = ram_rdata;
    end else begin
      ram_we    = ctl_i.fin && app_we;
      ram_waddr = cnt_q[AW-1:0];
      ram_wdata = val_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q      <= '0;
      rdat_vld_q <= 1'b0;
    end else begin
      cnt_q      <= cnt_d;
      rdat_vld_q <= rdat_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q   <= rd_idx_d;
    rdat_idx_q <= rdat_idx_d;
    best_val_q <= best_val_d;
    best_idx_q <= best_idx_d;
    if (ctl_i.load) begin
      cmd_q <= cmd_i;
      val_q <= value_i;
      lim_q <= (cmd_i == CMD_POP_OLDEST) ? CW'(1) : cnt_q;
    end
    if (ctl_i.fin) begin
      res_q     <= res_n;
      st_q      <= st_n;
      cnt_out_q <= cnt_wide[COUNT_W-1:0];
    end
  end

  assign value_res_o = res_q;
  assign status_o    = st_q;
  assign count_o     = cnt_out_q;

endmodule

>>> src/fifo_with_min_max_extract.sv
`timescale 1ns / 1ps
// Top level of the min/max extract queue: controller plus datapath.
// Depends on fmmx_pkg, fmmx_ctrl, fmmx_dp (and fmmx_ram below it).
//
// Usage:
//   An ordered queue of up to DEPTH signed 32-bit entries. The input channel
//   (in_valid_i/in_ready_o) carries cmd_i and value_i: append, remove oldest,
//   remove minimum, remove maximum or query count. Each command yields one
//   result transfer on the output channel (out_valid_o/out_ready_i) with the
//   removed value, a status code and the entry count after the command.
//   Ties on a min or max removal take the earliest entry; remaining entries
//   keep their order.
// Flow:
//   Commands are processed one at a time; the input is not taken again until
//   the command's result is loaded. Append, query and removals from an empty
//   queue go straight to loading the result. A removal from a non-empty queue
//   scans the entries through the single RAM read port (only the head for
//   remove oldest), then compacts the entries behind the removed one, one per
//   cycle, before the result is loaded. The next command is taken as soon as
//   the result is loaded, even while that result still waits for its
//   transfer.
// Reset:
//   rst_ni clears the count (queue empty) and all handshake state.
// Stall:
//   A held result stays on the output; a finished command waits for the
//   output register to drain before it commits.
module fifo_with_min_max_extract import fmmx_pkg::*; #(
  parameter int unsigned DEPTH = DEPTH_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic        [CMD_W-1:0]    cmd_i,
  input  logic signed [VAL_W-1:0]    value_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic signed [VAL_W-1:0]    value_res_o,
  output logic        [STATUS_W-1:0] status_o,
  output logic        [COUNT_W-1:0]  count_o
);

  dp_cmd_t ctl;
  dp_sts_t sts;

  // Sequence: accept, optional scan and compaction, then commit the result.
  fmmx_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .ctl_o       (ctl)
  );

  // Hold the entries, find the extreme entry and build the result.
  fmmx_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd_i),
    .value_i     (value_i),
    .ctl_i       (ctl),
    .sts_o       (sts),
    .value_res_o (value_res_o),
    .status_o    (status_o),
    .count_o     (count_o)
  );

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
// Testbench for fifo_with_min_max_extract: a queue-driven command driver and a
// result monitor, checked against an in-bench shadow queue. Depends on fmmx_pkg.
module testbench;
  import fmmx_pkg::*;

  localparam logic [CMD_W-1:0] CMD_LAST    = '1;    // highest encodable command
  localparam int unsigned      CYCLE_LIMIT = 400000;
  localparam int unsigned      DRAIN_WAIT  = 2 * DEPTH_DEF + 8;
  localparam int unsigned      HOLD_CYCLES = 300;
  localparam int unsigned      CALM_TAIL   = 120;   // last items sent without idling
  localparam int unsigned      RANDOM_CMDS = 820;

  typedef struct {
    logic [CMD_W-1:0]        cmd;
    logic signed [VAL_W-1:0] value;
  } queue_cmd_t;

  typedef struct {
    logic signed [VAL_W-1:0] value_res;
    logic [STATUS_W-1:0]     status;
    logic [COUNT_W-1:0]      count;
  } queue_result_t;

  // Clock, reset and block ports; every input starts at a known value.
  bit                       clk_i;
  logic                     rst_ni      = 1'b0;
  logic                     in_valid_i  = 1'b0;
  logic                     in_ready_o;
  logic [CMD_W-1:0]         cmd_i       = '0;
  logic signed [VAL_W-1:0]  value_i     = '0;
  logic                     out_valid_o;
  logic                     out_ready_i = 1'b0;
  logic signed [VAL_W-1:0]  value_res_o;
  logic [STATUS_W-1:0]      status_o;
  logic [COUNT_W-1:0]       count_o;

  // Stimulus waiting to be offered, and results the shadow queue predicts.
  queue_cmd_t               pending_cmds[$];
  queue_result_t            pending_results[$];
  logic signed [VAL_W-1:0]  shadow_q[$];

  logic                     cmd_taken = 1'b0;  // input transfer at the last rising edge
  int unsigned              cycle_count;
  int unsigned              cmds_accepted;
  int unsigned              mismatches;
  int unsigned              in_gap;
  int unsigned              out_gap;
  int unsigned              hold_left;
  int unsigned              holds_done;

  // Coverage tallies for the closing summary.
  int unsigned              n_append, n_dropped, n_remove, n_remove_empty, n_other;
  int unsigned              peak_fill;

  fifo_with_min_max_extract uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .cmd_i       (cmd_i),
    .value_i     (value_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .value_res_o (value_res_o),
    .status_o    (status_o),
    .count_o     (count_o)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // Apply one command to the shadow queue and return the result it produces.
  // Min/max removal takes the earliest of tied entries; the rest keep order.
  function automatic queue_result_t apply_queue_cmd(input logic [CMD_W-1:0] op,
                                                    input logic signed [VAL_W-1:0] val);
    queue_result_t r;
    int            pick;
    r.value_res = '0;
    r.status    = ST_OK;
    case (op)
      CMD_APPEND: begin
        // Drop the value when full.
        if (shadow_q.size() >= DEPTH_DEF) r.status = ST_FULL;
        else shadow_q.push_back(val);
      end
      CMD_POP_OLDEST, CMD_POP_MIN, CMD_POP_MAX: begin
        if (shadow_q.size() == 0) begin
          r.status = ST_EMPTY;
          if (op == CMD_POP_MIN) r.value_res = INT_MIN;
          else if (op == CMD_POP_MAX) r.value_res = INT_MAX;
        end else begin
          pick = 0;
          if (op != CMD_POP_OLDEST) begin
            for (int i = 1; i < shadow_q.size(); i++) begin
              if ((op == CMD_POP_MAX) ? (shadow_q[i] > shadow_q[pick])
                                      : (shadow_q[i] < shadow_q[pick]))
                pick = i;
            end
          end
          r.value_res = shadow_q[pick];
          shadow_q.delete(pick);
        end
      end
      default: ;  // query and spare codes leave the queue alone
    endcase
    r.count = COUNT_W'(shadow_q.size());
    return r;
  endfunction

  task automatic add_cmd(input logic [CMD_W-1:0] op, input logic signed [VAL_W-1:0] val);
    queue_cmd_t c;
    c.cmd   = op;
    c.value = val;
    pending_cmds.push_back(c);
  endtask

  // Favor a narrow band so ties are common, mix in the extremes and full words.
  function automatic logic signed [VAL_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return VAL_W'(int'($urandom_range(0, 8)) - 4);
      4:          return INT_MIN;
      5:          return INT_MAX;
      default:    return $urandom;
    endcase
  endfunction

  // Timeout: end the run if the block stops making progress.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Sample both channels at the rising edge. Predict on each input transfer,
  // then check each output transfer against the oldest prediction.
  always @(posedge clk_i) begin : sample_ports
    queue_result_t want;
    cmd_taken <= in_valid_i && in_ready_o;
    if (in_valid_i && in_ready_o) begin
      want = apply_queue_cmd(cmd_i, value_i);
      pending_results.push_back(want);
      cmds_accepted++;
      if (shadow_q.size() > peak_fill) peak_fill = shadow_q.size();
      case (cmd_i)
        CMD_APPEND: begin
          n_append++;
          if (want.status == ST_FULL) n_dropped++;
        end
        CMD_POP_OLDEST, CMD_POP_MIN, CMD_POP_MAX: begin
          n_remove++;
          if (want.status == ST_EMPTY) n_remove_empty++;
        end
        default: n_other++;
      endcase
    end
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        $error("result transfer with no command outstanding");
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (value_res_o !== want.value_res) begin
          $error("value_res: expected %0d, got %0d", want.value_res, value_res_o);
          mismatches++;
        end
        if (status_o !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status_o);
          mismatches++;
        end
        if (count_o !== want.count) begin
          $error("count: expected %0d, got %0d", want.count, count_o);
          mismatches++;
        end
      end
    end
  end

  // Command driver: change inputs at the falling edge. Hold valid and the
  // payload until the transfer; between items insert random idle bursts,
  // none once only the last stretch of stimulus remains.
  always @(negedge clk_i) begin : drive_cmds
    logic       next_valid;
    queue_cmd_t c;
    next_valid = in_valid_i;
    if (rst_ni && (cmd_taken || !in_valid_i)) begin
      next_valid = 1'b0;
      if (in_gap > 0) begin
        in_gap--;
      end else if (pending_cmds.size() > CALM_TAIL && $urandom_range(0, 99) < 12) begin
        in_gap = $urandom_range(1, 18) - 1;  // this cycle is the first idle one
      end else if (pending_cmds.size() != 0) begin
        c = pending_cmds.pop_front();
        cmd_i      <= c.cmd;
        value_i    <= c.value;
        next_valid = 1'b1;
      end
    end
    in_valid_i <= next_valid;
  end

  // Result receiver: stall in random bursts, and twice hold off for a long
  // stretch so the block backs up and stalls its input channel.
  always @(negedge clk_i) begin : drive_ready
    logic next_ready;
    next_ready = 1'b0;
    if (rst_ni) begin
      if (hold_left == 0 && ((holds_done == 0 && cmds_accepted >= 150) ||
                             (holds_done == 1 && cmds_accepted >= 450))) begin
        hold_left = HOLD_CYCLES;
        holds_done++;
      end
      if (hold_left > 0) begin
        hold_left--;
      end else if (out_gap > 0) begin
        out_gap--;
      end else if (pending_cmds.size() > CALM_TAIL && $urandom_range(0, 99) < 15) begin
        out_gap = $urandom_range(1, 18) - 1;
      end else begin
        next_ready = 1'b1;
      end
    end
    out_ready_i <= next_ready;
  end

  initial begin : run_test
    int unsigned made;
    int unsigned mode, len, r, app_pct;
    // Directed: every removal on empty, query, spare codes.
    add_cmd(CMD_QUERY, '0);
    add_cmd(CMD_POP_OLDEST, $urandom);
    add_cmd(CMD_POP_MIN, $urandom);
    add_cmd(CMD_POP_MAX, $urandom);
    for (int c = int'(CMD_QUERY) + 1; c <= int'(CMD_LAST); c++) add_cmd(CMD_W'(c), $urandom);
    // Fill with extremes and ties, extreme values at the head.
    add_cmd(CMD_APPEND, INT_MAX);
    add_cmd(CMD_APPEND, INT_MIN);
    add_cmd(CMD_APPEND, 7);
    add_cmd(CMD_APPEND, -1);
    add_cmd(CMD_APPEND, 7);
    add_cmd(CMD_APPEND, INT_MIN);
    add_cmd(CMD_APPEND, 0);
    add_cmd(CMD_APPEND, 1);
    for (int i = 0; i < DEPTH_DEF - 8; i++) add_cmd(CMD_APPEND, $urandom);
    add_cmd(CMD_APPEND, INT_MAX);  // full: dropped
    add_cmd(CMD_POP_MAX, '0);      // maximum sits at the head
    add_cmd(CMD_POP_MIN, '0);      // tied minimum, earliest now at the head
    add_cmd(CMD_POP_OLDEST, '0);
    add_cmd(CMD_QUERY, '1);

    // Random episodes: fill-heavy, drain-heavy or balanced runs.
    made = 0;
    while (made < RANDOM_CMDS) begin
      mode = $urandom_range(0, 2);
      len  = $urandom_range(8, 40);
      app_pct = (mode == 0) ? 70 : (mode == 1) ? 20 : 45;
      for (int i = 0; i < len; i++) begin
        r = $urandom_range(0, 99);
        if (r < app_pct) add_cmd(CMD_APPEND, pick_value());
        else if (r < 94) add_cmd(CMD_W'($urandom_range(CMD_POP_OLDEST, CMD_POP_MAX)), $urandom);
        else add_cmd(CMD_W'($urandom_range(CMD_QUERY, CMD_LAST)), $urandom);
        made++;
      end
    end

    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Wait until every command is transferred, then until every result is in.
    while (pending_cmds.size() != 0 || in_valid_i) @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);

    $display("Ran %0d commands: %0d appends (%0d dropped on full), %0d removals (%0d on empty),",
             cmds_accepted, n_append, n_dropped, n_remove, n_remove_empty);
    $display("  %0d queries or spare codes; peak occupancy %0d of %0d, %0d long output stalls.",
             n_other, peak_fill, DEPTH_DEF, holds_done);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
